// ===== sv/xei_pkg.sv =====
`default_nettype none

package xei_pkg;

  localparam int PANEL_COUNT = 2;
  localparam int PANEL_W     = 1;
  localparam int CODE_W      = 4;
  localparam int SEQ_W       = 2;
  localparam int RELAY_W     = 3;

  // panel status codes that the sequencer reacts to
  localparam logic [CODE_W-1:0] ST_READY_FOR_PULSE = 4'd3;
  localparam logic [CODE_W-1:0] ST_PULSE_SEEN      = 4'd4;
  localparam logic [CODE_W-1:0] ST_STANDBY_SEEN    = 4'd8;

  // generator sequence codes
  localparam logic [SEQ_W-1:0] SEQ_WAITING        = 2'd0;
  localparam logic [SEQ_W-1:0] SEQ_EXPOSE_REQUEST = 2'd1;
  localparam logic [SEQ_W-1:0] SEQ_EXPOSING       = 2'd2;

  // item kinds carried on tuser
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // relay latch bit positions
  localparam int RELAY_BEAM   = 0;
  localparam int RELAY_FIRST  = 1;
  localparam int RELAY_SECOND = 2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_FIELD_W = 17;

  typedef struct packed {
    logic                mode;
    logic [PANEL_W-1:0]  panel_index;
    logic [CODE_W-1:0]   status_code;
    logic                read_failed;
    logic [PANEL_W-1:0]  gen_selects_panel;
    logic                gen_expose;
    logic                first_panel_ready;
    logic                second_panel_ready;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]                    seq;
    logic [PANEL_W-1:0]                  choice;
    logic [PANEL_COUNT-1:0][CODE_W-1:0]  status;
    logic [RELAY_W-1:0]                  relays;
  } ilk_state_t;

  typedef struct packed {
    logic [CODE_W-1:0]   second_panel_status;
    logic [CODE_W-1:0]   first_panel_status;
    logic                wrong_panel_ready;
    logic [PANEL_W-1:0]  command_target;
    logic                cancel_issued;
    logic                unlock_issued;
    logic [SEQ_W-1:0]    sequence_state;
    logic                second_expose_relay;
    logic                first_expose_relay;
    logic                beam_relay_closed;
  } out_item_t;

  function automatic logic [RELAY_W-1:0] panel_relay_mask(input logic [PANEL_W-1:0] p);
    logic [RELAY_W-1:0] m;
    m = '0;
    if (p == PANEL_W'(1)) begin
      m[RELAY_SECOND] = 1'b1;
    end else begin
      m[RELAY_FIRST] = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/xray_exposure_interlock.sv =====
`default_nettype none

// interlock sequencer between an x-ray generator and two imaging panels. each input
// transfer is either a panel status report (tuser high), which overwrites that panel's
// status code, or a sampled tick of the relay inputs (tuser low), which steps the
// generator sequence: unlock when both panels are in standby, close the chosen panel's
// expose relay when it is ready for pulse, close the beam relay once its ready line rises,
// open the relays when expose drops, cancel the other panel if it is armed and flag the
// wrong panel raising ready. a tick with read_failed set changes nothing. every input
// transfer gives exactly one output transfer carrying the relay latches, sequence state,
// command flags and both status codes after the step. the block takes one transfer per
// cycle while the output is not stalled; a transfer passes through the input register,
// then the result register that the single next-state pass writes together with the state.
// gen_prep is carried on the bus but plays no part in the sequence.

module xray_exposure_interlock (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [0] panel_index, [4:1] status_code, [5] read_failed, [6] gen_selects_panel,
  // [7] gen_prep, [8] gen_expose, [9] first_panel_ready, [10] second_panel_ready
  input  wire  [xei_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] mode
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [0] beam_relay_closed, [1] first_expose_relay, [2] second_expose_relay,
  // [4:3] sequence_state, [5] unlock_issued, [6] cancel_issued, [7] command_target,
  // [8] wrong_panel_ready, [12:9] first_panel_status, [16:13] second_panel_status
  output logic [xei_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import xei_pkg::*;

  // input register
  logic       in_valid_r;
  in_item_t   in_item_r;
  in_item_t   in_item_nxt;

  // interlock state
  ilk_state_t state_r;
  ilk_state_t state_nxt;

  // result register
  logic       out_valid_r;
  out_item_t  out_item_r;
  out_item_t  out_item_nxt;

  logic       advance;
  logic       in_xfer;

  // the step fires when the result register is free or being drained this cycle
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_item_nxt.mode               = in_tuser;
    in_item_nxt.panel_index        = in_tdata[0];
    in_item_nxt.status_code        = in_tdata[4:1];
    in_item_nxt.read_failed        = in_tdata[5];
    in_item_nxt.gen_selects_panel  = in_tdata[6];
    in_item_nxt.gen_expose         = in_tdata[8];
    in_item_nxt.first_panel_ready  = in_tdata[9];
    in_item_nxt.second_panel_ready = in_tdata[10];
  end

  xei_step u_step (
    .st     (state_r),
    .item   (in_item_r),
    .st_nxt (state_nxt),
    .res    (out_item_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload of the input register needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.seq    <= SEQ_WAITING;
      state_r.choice <= '0;
      state_r.status <= '0;
      state_r.relays <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_item_r};

  // relays only stay closed while an exposure is under way
  a_relays_open_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.seq == SEQ_WAITING |-> state_r.relays == '0)
    else $error("relay closed while sequence waiting");

  // beam relay is closed exactly in the exposing phase
  a_beam_only_exposing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.relays[RELAY_BEAM] |-> state_r.seq == SEQ_EXPOSING)
    else $error("beam relay closed outside exposing");

  // unlock needs both panels in standby, cancel needs one armed
  a_unlock_cancel_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.unlock_issued && out_item_r.cancel_issued))
    else $error("unlock and cancel in one result");

  // wrong-panel flag only while an expose request is held
  a_wrong_panel_in_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.wrong_panel_ready |-> out_item_r.sequence_state != SEQ_WAITING)
    else $error("wrong panel flagged while waiting");

  // a result is produced for every step taken
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("step taken without result");

endmodule

`default_nettype wire

// ===== sv/xei_step.sv =====
`default_nettype none

module xei_step (
  input  xei_pkg::ilk_state_t st,
  input  xei_pkg::in_item_t   item,
  output xei_pkg::ilk_state_t st_nxt,
  output xei_pkg::out_item_t  res
);
  import xei_pkg::*;

  logic                unlock;
  logic                cancel;
  logic                wrong;
  logic [PANEL_W-1:0]  target;
  logic                chosen_rdy;
  logic                other_rdy;
  logic [PANEL_W-1:0]  other_sel;

  assign other_sel = ~item.gen_selects_panel;

  always_comb begin
    st_nxt     = st;
    unlock     = 1'b0;
    cancel     = 1'b0;
    wrong      = 1'b0;
    target     = '0;
    chosen_rdy = 1'b0;
    other_rdy  = 1'b0;
    if (item.mode == MODE_REPORT) begin
      st_nxt.status[item.panel_index] = item.status_code;
    end else if (!item.read_failed) begin
      // both panels parked in standby: release for prepare
      if (st.status[0] == ST_STANDBY_SEEN && st.status[1] == ST_STANDBY_SEEN) begin
        unlock = 1'b1;
        target = item.gen_selects_panel;
      end
      // new expose request
      if (item.gen_expose && st_nxt.seq == SEQ_WAITING) begin
        st_nxt.choice = item.gen_selects_panel;
        if (st_nxt.status[item.gen_selects_panel] == ST_READY_FOR_PULSE) begin
          st_nxt.relays = st_nxt.relays | panel_relay_mask(item.gen_selects_panel);
          st_nxt.status[item.gen_selects_panel] = ST_PULSE_SEEN;
          st_nxt.seq = SEQ_EXPOSE_REQUEST;
        end
      end
      // waiting for the chosen panel's ready line
      if (item.gen_expose && st_nxt.seq == SEQ_EXPOSE_REQUEST) begin
        chosen_rdy = st_nxt.choice[0] ? item.second_panel_ready : item.first_panel_ready;
        other_rdy  = st_nxt.choice[0] ? item.first_panel_ready : item.second_panel_ready;
        if (chosen_rdy) begin
          st_nxt.relays[RELAY_BEAM] = 1'b1;
          st_nxt.seq = SEQ_EXPOSING;
        end
        wrong = other_rdy;
      end
      // expose dropped: open beam and the chosen panel's relay
      if (!item.gen_expose && st_nxt.seq != SEQ_WAITING) begin
        st_nxt.relays[RELAY_BEAM] = 1'b0;
        st_nxt.relays = st_nxt.relays & ~panel_relay_mask(st_nxt.choice);
        st_nxt.seq = SEQ_WAITING;
      end
      // unselected panel armed: cancel its acquisition
      if (st_nxt.status[other_sel] == ST_READY_FOR_PULSE) begin
        cancel = 1'b1;
        target = other_sel;
      end
    end
  end

  always_comb begin
    res.beam_relay_closed   = st_nxt.relays[RELAY_BEAM];
    res.first_expose_relay  = st_nxt.relays[RELAY_FIRST];
    res.second_expose_relay = st_nxt.relays[RELAY_SECOND];
    res.sequence_state      = st_nxt.seq;
    res.unlock_issued       = unlock;
    res.cancel_issued       = cancel;
    res.command_target      = target;
    res.wrong_panel_ready   = wrong;
    res.first_panel_status  = st_nxt.status[0];
    res.second_panel_status = st_nxt.status[1];
  end

endmodule

`default_nettype wire
